@@ rtl/lbft_pkg.sv @@
// Shared types and constants for the learning bridge forwarding table.
// Used by the scan controller and the top level. No dependencies.
package lbft_pkg;

	// Table geometry.
	localparam int TABLE_ENTRIES = 128;
	localparam int ENTRY_W       = $clog2(TABLE_ENTRIES);
	localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);

	// Field widths.
	localparam int ADDR_W = 48;
	localparam int PORT_W = 2;
	localparam int ACT_W  = 2;

	// Forwarding decisions.
	localparam logic [ACT_W-1:0] ACT_FORWARD = 2'd0;
	localparam logic [ACT_W-1:0] ACT_DISCARD = 2'd1;
	localparam logic [ACT_W-1:0] ACT_FLOOD   = 2'd2;

	// One frame header request.
	typedef struct packed {
		logic [ADDR_W-1:0] dst_addr;
		logic [ADDR_W-1:0] src_addr;
		logic [PORT_W-1:0] in_port;
	} req_t;

	// One forwarding result.
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [PORT_W-1:0] out_port;
		logic              learned;
		logic              table_full;
	} rsp_t;

	// One stored table entry.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [PORT_W-1:0] port;
	} entry_t;

	// Table memory read and write commands.
	typedef struct packed {
		logic               re;
		logic [ENTRY_W-1:0] raddr;
	} mem_rd_t;

	typedef struct packed {
		logic               we;
		logic [ENTRY_W-1:0] waddr;
		entry_t             wdata;
	} mem_wr_t;

	// Controller status toward the top level.
	typedef struct packed {
		logic busy;
		logic done;
	} ctrl_status_t;

endpackage

@@ rtl/learning_bridge_forward_table_core.sv @@
// Top level of the learning bridge forwarding table: request handshake,
// result register and table memory. Uses lbft_pkg, lbft_ctrl and lbft_ram.
//
//  channel   direction  handshake             payload
//  request   in         req_valid/req_stall   req (dst_addr, src_addr, in_port)
//  result    out        rsp_valid/rsp_stall   rsp (action, out_port, learned, table_full)
//
// A result is ready once its request is accepted and the scan has read all fill entries,
// fill being the number of learned entries: the scan reads one entry per cycle through the
// single read port. The next request is accepted once the result has gone to the output
// register. Reset clears the fill count and the control state; the table memory needs no
// clearing pass. A stalled result waits in the output register while the next request is
// scanned; that request finishes, and writes the table, only once the register is free.
module learning_bridge_forward_table_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  lbft_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output lbft_pkg::rsp_t rsp
);
	import lbft_pkg::*;

	ctrl_status_t status;
	rsp_t         ctrl_rsp;
	mem_rd_t      mem_rd;
	mem_wr_t      mem_wr;
	entry_t       mem_rdata;
	logic         out_free;
	logic         start;
	logic         rsp_valid_q;
	rsp_t         rsp_q;

	assign req_stall = status.busy;
	assign start     = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	lbft_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req),
		.out_free  (out_free),
		.status    (status),
		.rsp       (ctrl_rsp),
		.mem_rd    (mem_rd),
		.mem_wr    (mem_wr),
		.mem_rdata (mem_rdata)
	);

	lbft_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_wr.we),
		.waddr (mem_wr.waddr),
		.wdata (mem_wr.wdata),
		.re    (mem_rd.re),
		.raddr (mem_rd.raddr),
		.rdata (mem_rdata)
	);

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (status.done && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (status.done && out_free) begin
			rsp_q <= ctrl_rsp;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	// An accepted request keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> req_stall)
		else $error("block not busy after accepting a request");

	// Learning and table-full are exclusive.
	a_learn_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.learned && rsp.table_full))
		else $error("learned and table_full both set");

	// Only a forward result carries a port.
	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && (rsp.action != ACT_FORWARD)) |-> (rsp.out_port == '0))
		else $error("out_port set on a non-forward result");

	// A table write only happens while a result is handed to the register.
	a_write_on_handover: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr.we |=> (rsp_valid && rsp.learned))
		else $error("table write without a learned result");
`endif

endmodule

@@ rtl/lbft_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Self-contained; no package dependency.
module lbft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/lbft_ctrl.sv @@
// Scan controller: linear lookup of destination and source over the filled
// entries, then the append of an unknown source while room remains. Uses lbft_pkg.
module lbft_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  lbft_pkg::req_t        req,
	input  logic                  out_free,
	output lbft_pkg::ctrl_status_t status,
	output lbft_pkg::rsp_t        rsp,
	output lbft_pkg::mem_rd_t     mem_rd,
	output lbft_pkg::mem_wr_t     mem_wr,
	input  lbft_pkg::entry_t      mem_rdata
);
	import lbft_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic [COUNT_W-1:0] fill_q;
	logic [COUNT_W-1:0] rd_idx_q;
	logic              cmp_s1;
	logic              dst_hit_q;
	logic [PORT_W-1:0] dst_port_q;
	logic              src_hit_q;

	logic issue_left;
	logic is_full;
	logic finish;
	logic do_learn;

	assign issue_left = rd_idx_q < fill_q;
	assign is_full    = fill_q == COUNT_W'(TABLE_ENTRIES);
	assign finish     = (state_q == S_DONE) && out_free;
	assign do_learn   = !src_hit_q && !is_full;

	// Read one entry per cycle while entries remain.
	assign mem_rd.re    = (state_q == S_SCAN) && issue_left;
	assign mem_rd.raddr = rd_idx_q[ENTRY_W-1:0];

	// Append the source at the fill point when the result is handed over.
	assign mem_wr.we         = finish && do_learn;
	assign mem_wr.waddr      = fill_q[ENTRY_W-1:0];
	assign mem_wr.wdata.addr = req_q.src_addr;
	assign mem_wr.wdata.port = req_q.in_port;

	assign status.busy = state_q != S_IDLE;
	assign status.done = state_q == S_DONE;

	// Result from the scan flags.
	always_comb begin
		rsp.action     = ACT_FLOOD;
		rsp.out_port   = '0;
		if (dst_hit_q) begin
			if (dst_port_q != req_q.in_port) begin
				rsp.action   = ACT_FORWARD;
				rsp.out_port = dst_port_q;
			end else begin
				rsp.action = ACT_DISCARD;
			end
		end
		rsp.learned    = do_learn;
		rsp.table_full = !src_hit_q && is_full;
	end

	// Sequencer and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			rd_idx_q <= '0;
			cmp_s1   <= 1'b0;
		end else begin
			cmp_s1 <= mem_rd.re;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						rd_idx_q <= '0;
						state_q  <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue_left) begin
						rd_idx_q <= rd_idx_q + COUNT_W'(1);
					end else if (!cmp_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						if (do_learn) begin
							fill_q <= fill_q + COUNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request capture and match tracking; the first destination match wins.
	always_ff @(posedge clk) begin
		if (start && (state_q == S_IDLE)) begin
			req_q     <= req;
			dst_hit_q <= 1'b0;
			src_hit_q <= 1'b0;
		end else if (cmp_s1) begin
			if (!dst_hit_q && (mem_rdata.addr == req_q.dst_addr)) begin
				dst_hit_q  <= 1'b1;
				dst_port_q <= mem_rdata.port;
			end
			if (mem_rdata.addr == req_q.src_addr) begin
				src_hit_q <= 1'b1;
			end
		end
	end

endmodule

@@ verif/learning_bridge_forward_table_checker.sv @@
// Scoreboard for the learning bridge forwarding table: watches both channels, predicts each
// result from its own copy of the address table and compares field by field.
// Depends on lbft_pkg for the request and result types and the table size.
module learning_bridge_forward_table_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	input  logic           req_stall,
	input  lbft_pkg::req_t req,
	input  logic           rsp_valid,
	input  logic           rsp_stall,
	input  lbft_pkg::rsp_t rsp,
	output int             pending,
	output int             mismatches
);
	import lbft_pkg::*;

	// Predicted table contents, filled in arrival order and never reordered.
	logic [ADDR_W-1:0] learned_addr [TABLE_ENTRIES];
	logic [PORT_W-1:0] learned_port [TABLE_ENTRIES];
	int                learned_count;
	rsp_t              expected_results [$];
	rsp_t              want;
	int                results_seen;

	// Scan the learned entries in order; the first match wins, -1 when absent.
	function automatic int find_slot(logic [ADDR_W-1:0] addr);
		for (int k = 0; k < learned_count; k++) begin
			if (learned_addr[k] == addr) return k;
		end
		return -1;
	endfunction

	// Look up the destination first, then learn the source if it is new and there is room.
	function automatic rsp_t forward_decision(req_t r);
		rsp_t d;
		int   slot;
		d = '0;
		d.action = ACT_FLOOD;
		slot = find_slot(r.dst_addr);
		if (slot >= 0) begin
			if (learned_port[slot] != r.in_port) begin
				d.action   = ACT_FORWARD;
				d.out_port = learned_port[slot];
			end else begin
				d.action = ACT_DISCARD;
			end
		end
		if (find_slot(r.src_addr) < 0) begin
			if (learned_count < TABLE_ENTRIES) begin
				learned_addr[learned_count] = r.src_addr;
				learned_port[learned_count] = r.in_port;
				learned_count++;
				d.learned = 1'b1;
			end else begin
				d.table_full = 1'b1;
			end
		end
		return d;
	endfunction

	// Print one mismatch line and count it.
	task automatic report_mismatch(string msg);
		$display("mismatch at result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	// Predict on every accepted request and compare every accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learned_count = 0;
			expected_results.delete();
			pending = 0;
			results_seen = 0;
		end else begin
			if (req_valid && !req_stall) begin
				expected_results.push_back(forward_decision(req));
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with no request waiting");
				end else begin
					want = expected_results.pop_front();
					if (rsp.action !== want.action)
						report_mismatch($sformatf("action %0d, expected %0d",
							rsp.action, want.action));
					if (rsp.out_port !== want.out_port)
						report_mismatch($sformatf("out_port %0d, expected %0d",
							rsp.out_port, want.out_port));
					if (rsp.learned !== want.learned)
						report_mismatch($sformatf("learned %0b, expected %0b",
							rsp.learned, want.learned));
					if (rsp.table_full !== want.table_full)
						report_mismatch($sformatf("table_full %0b, expected %0b",
							rsp.table_full, want.table_full));
				end
				results_seen++;
			end
			pending = expected_results.size();
		end
	end

endmodule

@@ verif/learning_bridge_forward_table_core_test.sv @@
// Testbench top for the learning bridge forwarding table: drives frame header requests,
// stalls the result side at random and gives the verdict.
// Depends on lbft_pkg, learning_bridge_forward_table_core and the checker module.
module learning_bridge_forward_table_core_test;
	import lbft_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int RANDOM_REQUESTS = 1500;
	localparam int STEADY_FIRST    = 400;
	localparam int STEADY_LAST     = 700;
	localparam int DRAIN_AT        = 900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic steady = 1'b0;
	int   pending;
	int   mismatches;
	int   cycles;
	logic [ADDR_W-1:0] addr_pool [$];

	// Clock with a period of 12.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	learning_bridge_forward_table_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	learning_bridge_forward_table_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp),
		.pending    (pending),
		.mismatches (mismatches)
	);

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The result side stalls at random, with a chance of about 7 in 100, except during the steady window.
	always @(negedge clk) begin
		rsp_stall <= !steady && ($urandom_range(0, 99) < 7);
	end

	function automatic logic [ADDR_W-1:0] random_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ADDR_W-1:0];
	endfunction

	// Present one request after an optional random gap and hold it until accepted.
	task automatic send_request(logic [ADDR_W-1:0] dst, logic [ADDR_W-1:0] src,
			logic [PORT_W-1:0] port);
		req_t r;
		r.dst_addr = dst;
		r.src_addr = src;
		r.in_port  = port;
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 7) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_stall);
		addr_pool.push_back(src);
	endtask

	// Hold off new requests until every result has come back.
	task automatic drain();
		@(negedge clk);
		req_valid <= 1'b0;
		wait (pending == 0);
	endtask

	initial begin
		logic [ADDR_W-1:0] dst;
		logic [ADDR_W-1:0] src;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty-table flood, forward, discard, known source on a new port,
		// source equal to destination, and the address extremes.
		send_request(48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, 2'd0);
		send_request(48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 2'd3);
		send_request(48'hFFFF_FFFF_FFFF, 48'h0123_4567_89AB, 2'd3);
		send_request(48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, 2'd1);
		send_request(48'h0000_0000_0000, 48'h0000_0000_0000, 2'd1);
		send_request(48'h8000_0000_0001, 48'h8000_0000_0001, 2'd2);
		send_request(48'h8000_0000_0001, 48'h7FFF_FFFF_FFFE, 2'd2);
		send_request(48'h7FFF_FFFF_FFFE, 48'h8000_0000_0001, 2'd1);
		send_request(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 2'd2);
		send_request(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 2'd1);
		send_request(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 2'd0);
		send_request(48'h0123_4567_89AB, 48'h0123_4567_89AB, 2'd3);
		send_request(48'h0000_0000_0000, 48'h0000_0000_0000, 2'd0);
		drain();

		// Random: mostly known addresses so lookups hit, with enough new sources
		// to fill the table and then run into the full case.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			steady <= (i >= STEADY_FIRST) && (i < STEADY_LAST);
			if (i == DRAIN_AT)
				drain();
			if ($urandom_range(0, 99) < 70)
				dst = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
			else
				dst = random_addr();
			if ($urandom_range(0, 99) < 20)
				src = random_addr();
			else
				src = addr_pool[$urandom_range(0, addr_pool.size() - 1)];
			send_request(dst, src, PORT_W'($urandom_range(0, 3)));
		end
		@(negedge clk);
		req_valid <= 1'b0;

		// Let everything drain, then allow one full scan for stray results.
		wait (pending == 0);
		repeat (TABLE_ENTRIES + 8) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
